[src/acir_pkg.sv]
// ----------------------------------------------------------------------------
// acir_pkg
// Shared types, constants and word-building functions for the AC IR frame
// encoder: state word layout, code tables and the queue/config structs.
// ----------------------------------------------------------------------------
`default_nettype none

package acir_pkg;

  // Frame geometry
  localparam int FRAME_BITS   = 48;
  localparam int WORD_BITS    = 24;
  localparam int TICK_W       = 15;
  localparam int SYM_CNT_W    = 6;
  localparam logic [SYM_CNT_W-1:0] STOP_SYM = SYM_CNT_W'(FRAME_BITS + 1);

  // Frame queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SPACE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MARK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_ONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_ZERO = 3'd4;

  // Requested mode values
  localparam logic [2:0] MODE_AUTO     = 3'd0;
  localparam logic [2:0] MODE_COOL     = 3'd1;
  localparam logic [2:0] MODE_DRY      = 3'd2;
  localparam logic [2:0] MODE_HEAT     = 3'd3;
  localparam logic [2:0] MODE_FAN_ONLY = 3'd4;

  // Mode codes placed in the state word
  localparam logic [1:0] MCODE_COOL = 2'd0;
  localparam logic [1:0] MCODE_DRY  = 2'd1;
  localparam logic [1:0] MCODE_AUTO = 2'd2;
  localparam logic [1:0] MCODE_HEAT = 2'd3;

  // Requested fan values
  localparam logic [2:0] FAN_LOW  = 3'd1;
  localparam logic [2:0] FAN_MED  = 3'd2;
  localparam logic [2:0] FAN_HIGH = 3'd3;

  // Fan codes placed in the state word
  localparam logic [2:0] FCODE_LOW      = 3'd4;
  localparam logic [2:0] FCODE_MED      = 3'd2;
  localparam logic [2:0] FCODE_HIGH     = 3'd1;
  localparam logic [2:0] FCODE_AUTO_DRY = 3'd0;
  localparam logic [2:0] FCODE_AUTO     = 3'd5;

  // Fixed words and temperature mapping
  localparam logic [WORD_BITS-1:0] WORD_DEFAULT = 24'hB21FC8;
  localparam logic [WORD_BITS-1:0] WORD_OFF     = 24'hB27BE0;
  localparam logic [3:0] TCODE_FAN_ONLY = 4'hE;
  localparam logic [7:0] TEMP_LO = 8'd17;
  localparam logic [7:0] TEMP_HI = 8'd30;
  localparam int TEMP_STEPS = 14;
  localparam logic [3:0] TEMP_MAP [TEMP_STEPS] = '{
    4'h0, 4'h1, 4'h3, 4'h2, 4'h6, 4'h7, 4'h5,
    4'h4, 4'hC, 4'hD, 4'h9, 4'h8, 4'hA, 4'hB
  };

  // Symbol timing registers
  typedef struct packed {
    logic [TICK_W-1:0] hdr_mark;
    logic [TICK_W-1:0] hdr_space;
    logic [TICK_W-1:0] data_mark;
    logic [TICK_W-1:0] space_one;
    logic [TICK_W-1:0] space_zero;
  } sym_cfg_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Build the 24-bit state word from one command
  function automatic logic [WORD_BITS-1:0] build_word(
    input logic       power_on,
    input logic [2:0] mode,
    input logic [7:0] temp,
    input logic [2:0] fan
  );
    logic [WORD_BITS-1:0] w;
    logic [1:0]           mcode;
    logic [3:0]           tcode;
    logic [2:0]           fcode;
    logic                 fan_only;
    logic [7:0]           tclamp;
    logic [3:0]           tidx;
    fan_only = 1'b0;
    unique case (mode)
      MODE_COOL:     mcode = MCODE_COOL;
      MODE_DRY:      mcode = MCODE_DRY;
      MODE_HEAT:     mcode = MCODE_HEAT;
      MODE_FAN_ONLY: begin
        mcode    = MCODE_DRY;
        fan_only = 1'b1;
      end
      default:       mcode = MCODE_AUTO;
    endcase

    // clamp to the table range before lookup
    if (temp < TEMP_LO) begin
      tclamp = TEMP_LO;
    end else if (temp > TEMP_HI) begin
      tclamp = TEMP_HI;
    end else begin
      tclamp = temp;
    end
    tidx  = 4'(tclamp - TEMP_LO);
    tcode = fan_only ? TCODE_FAN_ONLY : TEMP_MAP[tidx];

    unique case (fan)
      FAN_LOW:  fcode = FCODE_LOW;
      FAN_MED:  fcode = FCODE_MED;
      FAN_HIGH: fcode = FCODE_HIGH;
      default:  fcode = (mode == MODE_AUTO || mode == MODE_DRY) ? FCODE_AUTO_DRY
                                                                : FCODE_AUTO;
    endcase

    w         = WORD_DEFAULT;
    w[3:2]    = mcode;
    w[7:4]    = tcode;
    w[15:13]  = fcode;
    return power_on ? w : WORD_OFF;
  endfunction

  // Interleave each byte with its complement, high byte first
  function automatic logic [FRAME_BITS-1:0] wire_word(input logic [WORD_BITS-1:0] w);
    return {w[23:16], ~w[23:16], w[15:8], ~w[15:8], w[7:0], ~w[7:0]};
  endfunction

endpackage

`default_nettype wire

[src/ac_ir_frame_encoder_unit.sv]
// ----------------------------------------------------------------------------
// ac_ir_frame_encoder_unit
// Air-conditioner IR frame encoder: one command in, 50 pulse-distance
// symbols out (header, 48 data bits, stop).
// ----------------------------------------------------------------------------
// Each accepted command produces 50 result items, one per clock while the
// output is not stalled: the symbol sequencer in the back end emits one
// symbol a cycle from a 48-bit shift register. The front end registers the
// built wire word on acceptance and a two-entry frame queue sits between
// the two, so up to three commands can be taken while a frame is still
// being sent; the first header symbol goes from the word register through
// a queue entry to the output register. Symbol durations come from five
// 15-bit timing registers (reset 0) written through the cfg_ port, which
// is always ready; writes to indexes above 4 are ignored. Write them only
// while no frame is in flight.
`default_nettype none

module ac_ir_frame_encoder_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_power_on,
  input  wire logic [2:0]                   in_mode,
  input  wire logic [7:0]                   in_temp_celsius,
  input  wire logic [2:0]                   in_fan_speed,
  // symbol channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [acir_pkg::TICK_W-1:0]       out_mark_ticks,
  output logic [acir_pkg::TICK_W-1:0]       out_space_ticks,
  output logic                              out_last_symbol,
  // timing register writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [acir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [acir_pkg::TICK_W-1:0]  cfg_data
);

  acir_pkg::sym_cfg_t              sym_cfg_r;
  acir_pkg::q_status_t             q_status;
  logic                            q_push;
  logic [acir_pkg::FRAME_BITS-1:0] q_push_data;
  logic                            q_pop;
  logic [acir_pkg::FRAME_BITS-1:0] q_pop_data;

  assign cfg_ready = 1'b1;

  // Timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        acir_pkg::CFG_HDR_MARK:   sym_cfg_r.hdr_mark   <= cfg_data;
        acir_pkg::CFG_HDR_SPACE:  sym_cfg_r.hdr_space  <= cfg_data;
        acir_pkg::CFG_DATA_MARK:  sym_cfg_r.data_mark  <= cfg_data;
        acir_pkg::CFG_SPACE_ONE:  sym_cfg_r.space_one  <= cfg_data;
        acir_pkg::CFG_SPACE_ZERO: sym_cfg_r.space_zero <= cfg_data;
        default: ;
      endcase
    end
  end

  acir_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_power_on     (in_power_on),
    .in_mode         (in_mode),
    .in_temp_celsius (in_temp_celsius),
    .in_fan_speed    (in_fan_speed),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_push_data     (q_push_data)
  );

  acir_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  acir_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .sym_cfg         (sym_cfg_r),
    .q_status        (q_status),
    .q_pop_data      (q_pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mark_ticks  (out_mark_ticks),
    .out_space_ticks (out_space_ticks),
    .out_last_symbol (out_last_symbol)
  );

endmodule

`default_nettype wire

[src/acir_front.sv]
// ----------------------------------------------------------------------------
// acir_front
// Accepts commands, builds the 48-bit wire word and hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module acir_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_power_on,
  input  wire logic [2:0]                     in_mode,
  input  wire logic [7:0]                     in_temp_celsius,
  input  wire logic [2:0]                     in_fan_speed,
  input  wire acir_pkg::q_status_t            q_status,
  output logic                                q_push,
  output logic [acir_pkg::FRAME_BITS-1:0]     q_push_data
);

  logic                              word_valid_r;
  logic                              word_valid_nxt;
  logic [acir_pkg::FRAME_BITS-1:0]   word_r;
  logic                              accept;

  // Hold the built word until the queue has room
  assign q_push      = word_valid_r && !q_status.full;
  assign q_push_data = word_r;
  assign in_stall    = word_valid_r && q_status.full;
  assign accept      = in_valid && !in_stall;

  always_comb begin
    word_valid_nxt = word_valid_r;
    if (accept) begin
      word_valid_nxt = 1'b1;
    end else if (q_push) begin
      word_valid_nxt = 1'b0;
    end
  end

  // Classify the command and register its wire word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= 1'b0;
    end else begin
      word_valid_r <= word_valid_nxt;
    end
    if (accept) begin
      word_r <= acir_pkg::wire_word(acir_pkg::build_word(in_power_on, in_mode,
                                                         in_temp_celsius, in_fan_speed));
    end
  end

endmodule

`default_nettype wire

[src/acir_queue.sv]
// ----------------------------------------------------------------------------
// acir_queue
// Short frame queue that decouples command intake from symbol emission.
// ----------------------------------------------------------------------------
`default_nettype none

module acir_queue (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire logic [acir_pkg::FRAME_BITS-1:0] push_data,
  input  wire logic                           pop,
  output logic [acir_pkg::FRAME_BITS-1:0]     pop_data,
  output acir_pkg::q_status_t                 status
);

  logic [acir_pkg::FRAME_BITS-1:0]  entries_r [acir_pkg::QUEUE_DEPTH];
  logic [acir_pkg::QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [acir_pkg::QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [acir_pkg::QUEUE_CNT_W-1:0] count_r;
  logic [acir_pkg::QUEUE_CNT_W-1:0] count_nxt;

  assign pop_data     = entries_r[rd_ptr_r];
  assign status.full  = (count_r == acir_pkg::QUEUE_CNT_W'(acir_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + acir_pkg::QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - acir_pkg::QUEUE_CNT_W'(1);
    end
  end

  // Advance pointers and store pushed frames
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + acir_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + acir_pkg::QUEUE_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  // Occupancy checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= acir_pkg::QUEUE_CNT_W'(acir_pkg::QUEUE_DEPTH))
    else $error("frame queue over-filled");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("frame pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("frame popped from empty queue");

endmodule

`default_nettype wire

[src/acir_back.sv]
// ----------------------------------------------------------------------------
// acir_back
// Symbol sequencer: takes a frame from the queue and emits header, 48 data
// symbols and the stop symbol through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module acir_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire acir_pkg::sym_cfg_t              sym_cfg,
  input  wire acir_pkg::q_status_t             q_status,
  input  wire logic [acir_pkg::FRAME_BITS-1:0] q_pop_data,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [acir_pkg::TICK_W-1:0]          out_mark_ticks,
  output logic [acir_pkg::TICK_W-1:0]          out_space_ticks,
  output logic                                 out_last_symbol
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                            state_r, state_nxt;
  logic [acir_pkg::FRAME_BITS-1:0]   shift_r, shift_nxt;
  logic [acir_pkg::SYM_CNT_W-1:0]    sym_cnt_r, sym_cnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [acir_pkg::TICK_W-1:0]       mark_r, mark_nxt;
  logic [acir_pkg::TICK_W-1:0]       space_r, space_nxt;
  logic                              last_r, last_nxt;
  logic                              out_free;

  assign out_free        = !out_valid_r || !out_stall;
  assign q_pop           = (state_r == ST_IDLE) && out_free && !q_status.empty;
  assign out_valid       = out_valid_r;
  assign out_mark_ticks  = mark_r;
  assign out_space_ticks = space_r;
  assign out_last_symbol = last_r;

  // Pick the next symbol whenever the output register frees up
  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    sym_cnt_nxt   = sym_cnt_r;
    out_valid_nxt = out_valid_r;
    mark_nxt      = mark_r;
    space_nxt     = space_r;
    last_nxt      = last_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          out_valid_nxt = 1'b1;
          mark_nxt      = sym_cfg.hdr_mark;
          space_nxt     = sym_cfg.hdr_space;
          last_nxt      = 1'b0;
          shift_nxt     = q_pop_data;
          sym_cnt_nxt   = acir_pkg::SYM_CNT_W'(1);
          state_nxt     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          mark_nxt      = sym_cfg.data_mark;
          if (sym_cnt_r == acir_pkg::STOP_SYM) begin
            space_nxt   = '0;
            last_nxt    = 1'b1;
            sym_cnt_nxt = '0;
            state_nxt   = ST_IDLE;
          end else begin
            space_nxt   = shift_r[acir_pkg::FRAME_BITS-1] ? sym_cfg.space_one
                                                          : sym_cfg.space_zero;
            last_nxt    = 1'b0;
            shift_nxt   = {shift_r[acir_pkg::FRAME_BITS-2:0], 1'b0};
            sym_cnt_nxt = sym_cnt_r + acir_pkg::SYM_CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, frame shifter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sym_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sym_cnt_r   <= sym_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    shift_r <= shift_nxt;
    mark_r  <= mark_nxt;
    space_r <= space_nxt;
    last_r  <= last_nxt;
  end

  // Sequencer checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> (sym_cnt_r != '0 && sym_cnt_r <= acir_pkg::STOP_SYM))
    else $error("symbol counter out of range while running");

  a_stop_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && out_free && sym_cnt_r == acir_pkg::STOP_SYM)
    |=> (out_valid_r && last_r && state_r == ST_IDLE))
    else $error("stop symbol did not close the frame");

  a_last_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> state_r == ST_IDLE)
    else $error("stop symbol shown while frame still running");

  a_header_first: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && !last_r && mark_r == $past(sym_cfg.hdr_mark)))
    else $error("frame did not start with header symbol");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AC IR frame encoder. Commands are queued by a
// stimulus process and presented in bursts; every accepted command is turned
// into its 50 expected symbols by a local model of the state word and the
// pulse-distance timing, and each symbol leaving the block is compared in
// order. Timing registers are reloaded between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICK_W     = acir_pkg::TICK_W;
  localparam int CFG_IDX_W  = acir_pkg::CFG_IDX_W;
  localparam int FRAME_BITS = acir_pkg::FRAME_BITS;

  localparam int CLK_HALF     = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AFTER   = 60;
  localparam int RAND_PHASES  = 5;
  localparam int RAND_PER_PH  = 50;
  localparam int LIMIT_NS     = 10_000_000;

  localparam logic [2:0] FAN_REQ_AUTO  = 3'd0;

  localparam logic [23:0] BASE_WORD      = 24'hB21FC8;
  localparam logic [23:0] OFF_WORD       = 24'hB27BE0;
  localparam logic [3:0]  FAN_ONLY_TCODE = 4'hE;
  localparam logic [7:0]  T_MIN          = 8'd17;
  localparam logic [7:0]  T_MAX          = 8'd30;
  localparam logic [3:0]  TEMP_GRAY [14] = '{
    4'h0, 4'h1, 4'h3, 4'h2, 4'h6, 4'h7, 4'h5,
    4'h4, 4'hC, 4'hD, 4'h9, 4'h8, 4'hA, 4'hB
  };

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  typedef struct packed {
    logic       power_on;
    logic [2:0] mode;
    logic [7:0] temp;
    logic [2:0] fan;
  } ac_cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0] mark;
    logic [TICK_W-1:0] space;
    logic              last;
  } ir_symbol_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic                 in_power_on     = 1'b0;
  logic [2:0]           in_mode         = '0;
  logic [7:0]           in_temp_celsius = '0;
  logic [2:0]           in_fan_speed    = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [TICK_W-1:0]    out_mark_ticks;
  logic [TICK_W-1:0]    out_space_ticks;
  logic                 out_last_symbol;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [TICK_W-1:0]    cfg_data        = '0;

  ac_cmd_t           cmd_backlog [$];
  ir_symbol_t        symbols_due [$];
  logic [TICK_W-1:0] sym_timing [5] = '{default: '0};
  int                errors      = 0;
  int                cmds_taken  = 0;
  int                burst_left  = 0;
  int                gap_left    = 0;
  rx_pattern_t       rx_pattern  = RX_FREE;
  int                pattern_left = 0;
  logic              hold_off    = 1'b0;

  ac_ir_frame_encoder_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_power_on     (in_power_on),
    .in_mode         (in_mode),
    .in_temp_celsius (in_temp_celsius),
    .in_fan_speed    (in_fan_speed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mark_ticks  (out_mark_ticks),
    .out_space_ticks (out_space_ticks),
    .out_last_symbol (out_last_symbol),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // State word for one command
  function automatic logic [23:0] state_word(input ac_cmd_t c);
    logic [23:0] w;
    logic [7:0]  t;
    logic        fan_only;
    if (!c.power_on) return OFF_WORD;
    w        = BASE_WORD;
    fan_only = 1'b0;
    case (c.mode)
      acir_pkg::MODE_COOL:     w[3:2] = acir_pkg::MCODE_COOL;
      acir_pkg::MODE_DRY:      w[3:2] = acir_pkg::MCODE_DRY;
      acir_pkg::MODE_HEAT:     w[3:2] = acir_pkg::MCODE_HEAT;
      acir_pkg::MODE_FAN_ONLY: begin
        w[3:2]   = acir_pkg::MCODE_DRY;
        fan_only = 1'b1;
      end
      default:                 w[3:2] = acir_pkg::MCODE_AUTO;
    endcase
    // clamp into the table range
    t = (c.temp < T_MIN) ? T_MIN : (c.temp > T_MAX) ? T_MAX : c.temp;
    w[7:4] = fan_only ? FAN_ONLY_TCODE : TEMP_GRAY[int'(t - T_MIN)];
    case (c.fan)
      acir_pkg::FAN_LOW:  w[15:13] = acir_pkg::FCODE_LOW;
      acir_pkg::FAN_MED:  w[15:13] = acir_pkg::FCODE_MED;
      acir_pkg::FAN_HIGH: w[15:13] = acir_pkg::FCODE_HIGH;
      default:  w[15:13] = (c.mode == acir_pkg::MODE_AUTO || c.mode == acir_pkg::MODE_DRY)
                           ? acir_pkg::FCODE_AUTO_DRY : acir_pkg::FCODE_AUTO;
    endcase
    return w;
  endfunction

  // Queue the header, 48 data symbols and the stop symbol of one command
  task automatic predict_frame(input ac_cmd_t c);
    logic [23:0]          w;
    logic [FRAME_BITS-1:0] bits;
    ir_symbol_t           s;
    w    = state_word(c);
    bits = {w[23:16], ~w[23:16], w[15:8], ~w[15:8], w[7:0], ~w[7:0]};
    s = '{sym_timing[acir_pkg::CFG_HDR_MARK], sym_timing[acir_pkg::CFG_HDR_SPACE], 1'b0};
    symbols_due.push_back(s);
    for (int i = FRAME_BITS - 1; i >= 0; i--) begin
      s = '{sym_timing[acir_pkg::CFG_DATA_MARK],
            bits[i] ? sym_timing[acir_pkg::CFG_SPACE_ONE]
                    : sym_timing[acir_pkg::CFG_SPACE_ZERO], 1'b0};
      symbols_due.push_back(s);
    end
    s = '{sym_timing[acir_pkg::CFG_DATA_MARK], '0, 1'b1};
    symbols_due.push_back(s);
  endtask

  function automatic int sender_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 0;
      6, 7:             return $urandom_range(1, 4);
      8:                return $urandom_range(5, 30);
      default:          return $urandom_range(31, 90);
    endcase
  endfunction

  function automatic ac_cmd_t random_cmd();
    ac_cmd_t c;
    c.power_on = ($urandom_range(0, 7) != 0);
    c.mode     = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
    c.temp     = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(T_MIN, T_MAX));
    c.fan      = 3'($urandom_range(0, 7));
    return c;
  endfunction

  task automatic push_cmd(input logic p, input logic [2:0] m, input logic [7:0] t,
                          input logic [2:0] f);
    cmd_backlog.push_back(ac_cmd_t'({p, m, t, f}));
  endtask

  // Write one timing register; valid stays high for the next write
  task automatic write_timing(input logic [CFG_IDX_W-1:0] idx,
                              input logic [TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= acir_pkg::CFG_SPACE_ZERO) sym_timing[idx] = val;
  endtask

  task automatic load_timing(input logic [TICK_W-1:0] hm, input logic [TICK_W-1:0] hs,
                             input logic [TICK_W-1:0] bm, input logic [TICK_W-1:0] os,
                             input logic [TICK_W-1:0] zs);
    write_timing(acir_pkg::CFG_HDR_MARK, hm);
    write_timing(acir_pkg::CFG_HDR_SPACE, hs);
    // unused indexes must be dropped by the block
    write_timing(CFG_IDX_W'($urandom_range(acir_pkg::CFG_SPACE_ZERO + 1, CFG_IDX_TOP)),
                 TICK_W'($urandom));
    write_timing(acir_pkg::CFG_DATA_MARK, bm);
    write_timing(acir_pkg::CFG_SPACE_ONE, os);
    write_timing(acir_pkg::CFG_SPACE_ZERO, zs);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued command has been sent and every symbol seen
  task automatic settle();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || in_valid || symbols_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [TICK_W-1:0] want,
                             input logic [TICK_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Command driver: bursts of items with random gaps, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frame(ac_cmd_t'({in_power_on, in_mode, in_temp_celsius, in_fan_speed}));
        cmds_taken <= cmds_taken + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          {in_power_on, in_mode, in_temp_celsius, in_fan_speed} <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left   <= sender_gap();
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Symbol monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (symbols_due.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected symbol, expected none, actual mark %0d space %0d last %0b",
                   $time, out_mark_ticks, out_space_ticks, out_last_symbol);
        end else begin
          ir_symbol_t want;
          want = symbols_due.pop_front();
          check_field("mark_ticks", want.mark, out_mark_ticks);
          check_field("space_ticks", want.space, out_space_ticks);
          check_field("last_symbol", TICK_W'(want.last), TICK_W'(out_last_symbol));
        end
      end
      // advance the stall pattern
      if (pattern_left == 0) begin
        rx_pattern   <= rx_pattern_t'($urandom_range(0, 3));
        pattern_left <= $urandom_range(40, 300);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (rx_pattern)
        RX_FREE:  out_stall <= hold_off;
        RX_LIGHT: out_stall <= hold_off || ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= hold_off || ($urandom_range(0, 3) != 0);
        default:  out_stall <= hold_off || (pattern_left % 3 == 0);
      endcase
    end
  end

  // Long receiver hold-off so the block fills up and stalls its input
  initial begin : rx_hold
    do @(posedge clk); while (cmds_taken < HOLD_AFTER);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stimulus and end of run
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // durations still at their reset value of zero
    push_cmd(1'b0, acir_pkg::MODE_AUTO, 8'd0, FAN_REQ_AUTO);
    push_cmd(1'b0, 3'd7, 8'd255, 3'd7);
    push_cmd(1'b1, acir_pkg::MODE_COOL, 8'd24, acir_pkg::FAN_HIGH);
    push_cmd(1'b1, acir_pkg::MODE_FAN_ONLY, 8'd22, FAN_REQ_AUTO);
    settle();

    load_timing(15'd9000, 15'd4500, 15'd560, 15'd1690, 15'd560);
    // every mode with auto fan, unknown modes included
    for (int m = 0; m < 8; m++) push_cmd(1'b1, 3'(m), 8'(T_MIN + 2 * m), FAN_REQ_AUTO);
    // temperatures below and above the clamp range
    push_cmd(1'b1, acir_pkg::MODE_HEAT, 8'd0, acir_pkg::FAN_MED);
    push_cmd(1'b1, acir_pkg::MODE_HEAT, 8'd16, acir_pkg::FAN_MED);
    push_cmd(1'b1, acir_pkg::MODE_HEAT, 8'd31, acir_pkg::FAN_MED);
    push_cmd(1'b1, acir_pkg::MODE_HEAT, 8'd255, acir_pkg::FAN_MED);
    // every fan request other than auto, unknown speeds included
    for (int f = 1; f < 8; f++) push_cmd(1'b1, acir_pkg::MODE_DRY, T_MAX, 3'(f));
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       load_timing('1, '1, '1, '1, '1);
        1:       load_timing('0, '0, '0, '0, '0);
        3:       load_timing(15'h5555, 15'h2AAA, 15'h0001, 15'h4000, 15'h3FFF);
        default: load_timing(TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom),
                             TICK_W'($urandom), TICK_W'($urandom));
      endcase
      for (int n = 0; n < RAND_PER_PH; n++) cmd_backlog.push_back(random_cmd());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && symbols_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
